// ===== hdl/uart_dual_ring_buffer_core_macros.svh =====
// Assertion macros shared by the ring buffer core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef UART_DUAL_RING_BUFFER_CORE_MACROS_SVH
`define UART_DUAL_RING_BUFFER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge outside reset.
`define UDRB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define UDRB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define UDRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define UDRB_ASSERT(lbl, clk, rst, prop, msg)
`define UDRB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define UDRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/udrb_pkg.sv =====
`default_nettype none

package udrb_pkg;

  // Entries in each ring
  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    OP_HOST_WRITE = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_LINE_RX    = 2'd2,
    OP_TX_READY   = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;  // act on the accepted transaction
    logic load;  // move the finished result into the output register
  } ctrl_cmd_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t wrap_at;
    wrap_at = PTR_W'(DEPTH - 1);
    return (p == wrap_at) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/udrb_ram.sv =====
`default_nettype none

module udrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/udrb_ctrl.sv =====
`default_nettype none
`include "uart_dual_ring_buffer_core_macros.svh"

module udrb_ctrl
  import udrb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign cmd.exec = (state == ST_IDLE) && in_valid;
  assign cmd.load = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `UDRB_ASSERT_NEXT(a_exec_stalls, clk, rst, cmd.exec, in_stall, "input not held after accept")
  `UDRB_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load, out_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== hdl/udrb_dpath.sv =====
`default_nettype none
`include "uart_dual_ring_buffer_core_macros.svh"

module udrb_dpath
  import udrb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [1:0]          op,
  input  wire logic [BYTE_W-1:0]   data_in,
  output logic      [BYTE_W-1:0]   data_out,
  output logic                     data_valid,
  output logic                     accepted,
  output logic                     tx_enable,
  output logic      [COUNT_W-1:0]  tx_count,
  output logic      [COUNT_W-1:0]  rx_count
);

  op_t   op_dec;
  ptr_t  tx_head, tx_tail, rx_head, rx_tail;
  cnt_t  tx_fill, rx_fill;
  logic  tx_en;
  logic  res_acc, res_valid, res_from_tx;
  logic  tx_full, tx_empty, rx_full, rx_empty;
  logic  tx_push, tx_pop, rx_push, rx_pop;
  byte_t tx_rdata, rx_rdata;

  assign op_dec   = op_t'(op);
  assign tx_full  = (tx_fill == CNT_W'(DEPTH));
  assign rx_full  = (rx_fill == CNT_W'(DEPTH));
  assign tx_empty = (tx_fill == '0);
  assign rx_empty = (rx_fill == '0);

  assign tx_push = cmd.exec && (op_dec == OP_HOST_WRITE) && !tx_full;
  assign tx_pop  = cmd.exec && (op_dec == OP_TX_READY)   && !tx_empty;
  assign rx_push = cmd.exec && (op_dec == OP_LINE_RX)    && !rx_full;
  assign rx_pop  = cmd.exec && (op_dec == OP_HOST_READ)  && !rx_empty;

  udrb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_push),
    .waddr (tx_tail),
    .wdata (data_in),
    .re    (tx_pop),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  udrb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_push),
    .waddr (rx_tail),
    .wdata (data_in),
    .re    (rx_pop),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      tx_fill <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      rx_fill <= '0;
      tx_en   <= 1'b0;
    end else begin
      if (tx_push) begin
        tx_tail <= next_ptr(tx_tail);
        tx_fill <= cnt_t'(tx_fill + 1'b1);
      end
      if (tx_pop) begin
        tx_head <= next_ptr(tx_head);
        tx_fill <= cnt_t'(tx_fill - 1'b1);
      end
      if (rx_push) begin
        rx_tail <= next_ptr(rx_tail);
        rx_fill <= cnt_t'(rx_fill + 1'b1);
      end
      if (rx_pop) begin
        rx_head <= next_ptr(rx_head);
        rx_fill <= cnt_t'(rx_fill - 1'b1);
      end
      if (cmd.exec && (op_dec == OP_HOST_WRITE)) begin
        tx_en <= 1'b1;
      end else if (cmd.exec && (op_dec == OP_TX_READY) && tx_empty) begin
        tx_en <= 1'b0;
      end
    end
  end

  // Per-transaction result flags and output payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_acc     <= tx_push || rx_push;
      res_valid   <= tx_pop || rx_pop;
      res_from_tx <= (op_dec == OP_TX_READY);
    end
    if (cmd.load) begin
      data_out   <= res_valid ? (res_from_tx ? tx_rdata : rx_rdata) : '0;
      data_valid <= res_valid;
      accepted   <= res_acc;
      tx_enable  <= tx_en;
      tx_count   <= COUNT_W'(tx_fill);
      rx_count   <= COUNT_W'(rx_fill);
    end
  end

  `UDRB_ASSERT(a_tx_ptrs, clk, rst, (tx_head == tx_tail) == (tx_empty || tx_full), "tx pointers disagree with fill")
  `UDRB_ASSERT(a_rx_ptrs, clk, rst, (rx_head == rx_tail) == (rx_empty || rx_full), "rx pointers disagree with fill")

endmodule

`default_nettype wire

// ===== hdl/uart_dual_ring_buffer_core.sv =====
`default_nettype none
// Transmit and receive byte queues for a serial port, 16 entries each, one
// result transaction per input transaction. op selects the event: a host
// write queues data_in for transmission (dropped with accepted low when the
// queue is full) and sets tx_enable; a host read pops the oldest received
// byte; a line receive queues data_in (dropped, accepted low, when full); a
// transmitter-ready event pops the next byte to send, or clears tx_enable
// when the transmit queue is empty. data_out is zero whenever data_valid is
// low. For each input transaction the accept cycle updates the pointers and
// either writes the queue RAM or issues its read; the done state that follows
// moves the registered RAM read data and status into the output
// register. The done state stretches while the output register still holds
// a transaction the sink has not taken; a new input transaction may be
// accepted while a finished result waits there. No clearing pass follows
// reset: queue entries are only read after they are written.

module uart_dual_ring_buffer_core
  import udrb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          op,
  input  wire logic [BYTE_W-1:0]   data_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [BYTE_W-1:0]   data_out,
  output logic                     data_valid,
  output logic                     accepted,
  output logic                     tx_enable,
  output logic      [COUNT_W-1:0]  tx_count,
  output logic      [COUNT_W-1:0]  rx_count
);

  ctrl_cmd_t cmd;

  // Sequence accept, result load and output handshake
  udrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Hold both rings, their pointers and fill counts, and the result register
  udrb_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .data_in    (data_in),
    .data_out   (data_out),
    .data_valid (data_valid),
    .accepted   (accepted),
    .tx_enable  (tx_enable),
    .tx_count   (tx_count),
    .rx_count   (rx_count)
  );

endmodule

`default_nettype wire

// ===== test/tb_uart_dual_ring_buffer_core.sv =====
`default_nettype none

module tb_uart_dual_ring_buffer_core;
  import udrb_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 826;
  localparam int QUIET_TAIL   = 80;    // final items sent with no idling
  localparam int HOLD_AFTER   = 300;   // replies seen before the long sink hold
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 20;

  // Random mix of event kinds for one stretch of the stream
  typedef enum int {
    MIX_EVEN,
    MIX_TX_HEAVY,
    MIX_RX_HEAVY,
    MIX_DRAIN
  } mix_t;

  typedef struct {
    op_t   op;
    byte_t data;
  } uart_item_t;

  typedef struct {
    byte_t              byte_out;
    logic               has_byte;
    logic               stored;
    logic               tx_en;
    logic [COUNT_W-1:0] tx_fill;
    logic [COUNT_W-1:0] rx_fill;
  } reply_t;

  // Clock and reset; every input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         op        = '0;
  logic [BYTE_W-1:0]  data_in   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  data_out;
  logic               data_valid;
  logic               accepted;
  logic               tx_enable;
  logic [COUNT_W-1:0] tx_count;
  logic [COUNT_W-1:0] rx_count;

  uart_dual_ring_buffer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .data_valid (data_valid),
    .accepted   (accepted),
    .tx_enable  (tx_enable),
    .tx_count   (tx_count),
    .rx_count   (rx_count)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Shadow copy of both rings and the transmit-ready enable
  byte_t              tx_ring [DEPTH];
  byte_t              rx_ring [DEPTH];
  ptr_t               tx_rd = '0, tx_wr = '0, rx_rd = '0, rx_wr = '0;
  logic [COUNT_W-1:0] tx_used = '0, rx_used = '0;
  logic               tx_armed = 1'b0;

  uart_item_t host_line_events [$];   // transactions still to offer
  reply_t     predicted_replies [$];  // replies owed by the block, oldest first

  uart_item_t on_offer;
  bit         offering     = 1'b0;
  bit         quiet_tail   = 1'b0;
  int         send_gap     = 0;
  int         sink_gap     = 0;
  int         hold_left    = 0;
  bit         hold_done    = 1'b0;
  int         replies_seen = 0;
  int         errors       = 0;
  int         stuck        = 0;

  function automatic ptr_t ring_step(ptr_t p);
    return (int'(p) == DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  // Advance the shadow rings by one event and return the status it produces
  function automatic reply_t apply_event(uart_item_t it);
    reply_t r;
    r = '{default: '0};
    case (it.op)
      OP_HOST_WRITE: begin
        if (tx_used < DEPTH) begin
          tx_ring[tx_wr] = it.data;
          tx_wr          = ring_step(tx_wr);
          tx_used        = tx_used + 1'b1;
          r.stored       = 1'b1;
        end
        // Arm even when the byte is dropped; a full ring already has it set
        tx_armed = 1'b1;
      end
      OP_HOST_READ: begin
        if (rx_used != 0) begin
          r.byte_out = rx_ring[rx_rd];
          r.has_byte = 1'b1;
          rx_rd      = ring_step(rx_rd);
          rx_used    = rx_used - 1'b1;
        end
      end
      OP_LINE_RX: begin
        // A full receive ring drops the byte, with stored left low
        if (rx_used < DEPTH) begin
          rx_ring[rx_wr] = it.data;
          rx_wr          = ring_step(rx_wr);
          rx_used        = rx_used + 1'b1;
          r.stored       = 1'b1;
        end
      end
      default: begin
        // Transmitter ready is not gated by the enable; empty ring disarms
        if (tx_used != 0) begin
          r.byte_out = tx_ring[tx_rd];
          r.has_byte = 1'b1;
          tx_rd      = ring_step(tx_rd);
          tx_used    = tx_used - 1'b1;
        end else begin
          tx_armed = 1'b0;
        end
      end
    endcase
    r.tx_en   = tx_armed;
    r.tx_fill = tx_used;
    r.rx_fill = rx_used;
    return r;
  endfunction

  function automatic op_t pick_op(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_TX_HEAVY: return (roll < 70) ? OP_HOST_WRITE : (roll < 80) ? OP_TX_READY :
                           (roll < 90) ? OP_LINE_RX : OP_HOST_READ;
      MIX_RX_HEAVY: return (roll < 70) ? OP_LINE_RX : (roll < 80) ? OP_HOST_READ :
                           (roll < 90) ? OP_HOST_WRITE : OP_TX_READY;
      MIX_DRAIN:    return (roll < 40) ? OP_HOST_READ : (roll < 80) ? OP_TX_READY :
                           (roll < 90) ? OP_HOST_WRITE : OP_LINE_RX;
      default:      return op_t'(roll % 4);
    endcase
  endfunction

  task automatic queue_item(op_t o, byte_t d);
    host_line_events.push_back('{op: o, data: d});
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH @%0t reply %0d: %s", $realtime, replies_seen, what);
  endtask

  // Build the stimulus: a directed opening, then stretches of biased random mixes
  initial begin
    mix_t mix;
    int   count;
    int   stretch;

    // Transmitter ready and host read against empty rings, enable still low
    queue_item(OP_TX_READY, 8'h5A);
    queue_item(OP_HOST_READ, 8'hC3);
    // Two writes at the byte extremes, drain them, then disarm on empty
    queue_item(OP_HOST_WRITE, 8'h00);
    queue_item(OP_HOST_WRITE, 8'hFF);
    queue_item(OP_TX_READY, 8'hFF);
    queue_item(OP_TX_READY, 8'h00);
    queue_item(OP_TX_READY, 8'hA5);
    // Fill the receive ring and push one more so that it gets dropped
    for (int k = 0; k <= DEPTH; k++) begin
      queue_item(OP_LINE_RX, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : byte_t'($urandom));
    end
    queue_item(OP_HOST_READ, 8'h00);

    count = 0;
    while (count < RANDOM_ITEMS) begin
      mix     = mix_t'($urandom_range(0, 3));
      stretch = $urandom_range(15, 50);
      for (int k = 0; k < stretch && count < RANDOM_ITEMS; k++) begin
        queue_item(pick_op(mix), byte_t'($urandom));
        count++;
      end
    end
  end

  // Reset, then wait out the stream and the drain before the verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (host_line_events.size() != 0 || offering) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("uart_dual_ring_buffer_core test passed");
    end else begin
      $display("uart_dual_ring_buffer_core test failed");
    end
    $finish;
  end

  // Input driver: present the next transaction at the falling edge, hold it while stalled
  always @(negedge clk) begin
    if (!rst) begin
      quiet_tail = (host_line_events.size() < QUIET_TAIL);
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (host_line_events.size() != 0) begin
          on_offer = host_line_events.pop_front();
          op       <= on_offer.op;
          data_in  <= on_offer.data;
          in_valid <= 1'b1;
          offering = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: random bursts, one long hold to back the block up into its input
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && replies_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 19);
      end
    end
  end

  // Monitor: check the reply taken at this edge, then predict for the input taken
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("reply with no transaction outstanding");
        end else begin
          want = predicted_replies.pop_front();
          if (data_out !== want.byte_out)
            report_mismatch($sformatf("data_out %0h, want %0h", data_out, want.byte_out));
          if (data_valid !== want.has_byte)
            report_mismatch($sformatf("data_valid %0b, want %0b", data_valid, want.has_byte));
          if (accepted !== want.stored)
            report_mismatch($sformatf("accepted %0b, want %0b", accepted, want.stored));
          if (tx_enable !== want.tx_en)
            report_mismatch($sformatf("tx_enable %0b, want %0b", tx_enable, want.tx_en));
          if (tx_count !== want.tx_fill)
            report_mismatch($sformatf("tx_count %0d, want %0d", tx_count, want.tx_fill));
          if (rx_count !== want.rx_fill)
            report_mismatch($sformatf("rx_count %0d, want %0d", rx_count, want.rx_fill));
        end
        replies_seen++;
      end
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(apply_event(on_offer));
        offering = 1'b0;
        // Drop in an occasional idle burst before the next transaction
        if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog: end the run when neither side has moved a transaction for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("uart_dual_ring_buffer_core test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
